### hdl/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies; imported by sha_core and sha256_stream_hash.
package sha_pkg;

  typedef logic [31:0] word_t;

  // Command from the byte sequencer to the compression core
  typedef struct packed {
    logic start;  // compress the presented block into the hash state
    logic init;   // load the initial vector into the hash state
  } core_cmd_t;

  // Status from the compression core
  typedef struct packed {
    logic busy;   // a block is being compressed
    logic done;   // one-cycle pulse, hash state updated
  } core_sts_t;

  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_POS     = 56;   // first byte of the length field
  localparam logic [7:0]  PAD_BYTE    = 8'h80;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants
  function automatic word_t k_const(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

### hdl/sha_core.sv
// SHA-256 compression core: one round per cycle over a 16-word schedule window,
// then a fold step that adds the working variables into the hash state.
// Depends on sha_pkg.
module sha_core
  import sha_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  core_cmd_t     cmd,
  input  logic [511:0]  block,      // word 0 in bits 511:480
  output core_sts_t     sts,
  output word_t         hash [8]
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} core_state_t;

  core_state_t  state;
  logic         done;
  logic [5:0]   round;
  word_t        h_reg [8];
  word_t        v [8];
  word_t        w [16];

  word_t t1, t2, w_new, choose, major;

  // Round datapath and schedule expansion
  always_comb begin
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1     = v[7] + big_sigma1(v[4]) + choose + k_const(round) + w[0];
    t2     = big_sigma0(v[0]) + major;
    w_new  = small_sigma1(w[14]) + w[9] + small_sigma0(w[1]) + w[0];
  end

  // Sequencer, hash state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      round <= '0;
      for (int i = 0; i < 8; i++) h_reg[i] <= IV[i];
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (cmd.init) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= IV[i];
          end
          if (cmd.start) begin
            for (int i = 0; i < 8; i++) v[i] <= h_reg[i];
            for (int i = 0; i < 16; i++) w[i] <= block[511 - 32*i -: 32];
            round <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          round <= round + 6'd1;
          if (round == 6'(ROUNDS - 1)) state <= C_ADD;
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v[i];
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign sts.busy = (state != C_IDLE);
  assign sts.done = done;
  assign hash     = h_reg;

  // A block is only started while the core is free
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> state == C_IDLE)
    else $error("compress started while core busy");

  // The last round always hands over to the fold state
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == C_ROUND && round == 6'(ROUNDS - 1)) |=> (state == C_ADD && !done))
    else $error("round sequence did not end in fold");

  // Done follows the fold state and nothing else
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == C_ADD))
    else $error("done without fold");

endmodule

### hdl/sha256_stream_hash.sv
// Top level of the SHA-256 stream hasher: byte gathering, padding sequencer,
// digest output. Depends on sha_pkg and sha_core.
//
//  channel | dir | tdata              | tuser      | tlast
//  s_*     | in  | [7:0] data_byte    | byte_valid | last
//  m_*     | out | [31:0] digest_word | -          | word_last
//
// The 64th byte of a block starts a compression (64 rounds in the shared
// round unit plus load and fold); no bytes are taken until it is finished.
// On a last request padding fills the rest of the block byte by byte (and a
// second block when the length does not fit), then the digest goes out as
// eight requests, H0 first. s_tready is high only while the sequencer waits
// for bytes; m_* stalls hold the digest word in its register. Reset is
// synchronous and restores the initial vector with a zero byte count.
module sha256_stream_hash
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] byte_valid
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic        m_tlast
);

  typedef enum logic [2:0] {IDLE, PAD_INIT, PAD, COMP, OUT} seq_state_t;

  seq_state_t    state;
  logic [60:0]   byte_count;
  logic [511:0]  blk;          // byte shift line, oldest byte at the top
  logic [5:0]    fill;
  logic [63:0]   len_sh;
  logic          first;
  logic          final_blk;
  logic          pad_act;
  logic          last_pend;
  logic [2:0]    out_idx;
  core_cmd_t     cmd;
  core_sts_t     sts;
  word_t         hash [8];
  logic [7:0]    pad_byte;
  logic          len_byte;

  sha_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .block (blk),
    .sts   (sts),
    .hash  (hash)
  );

  assign s_tready = (state == IDLE);

  // Padding byte: marker, zeros, then the bit length in the final block
  assign len_byte = final_blk && (fill >= 6'(LEN_POS));
  always_comb begin
    if (first)         pad_byte = PAD_BYTE;
    else if (len_byte) pad_byte = len_sh[63:56];
    else               pad_byte = 8'h00;
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      byte_count <= '0;
      cmd        <= '0;
      m_tvalid   <= 1'b0;
      m_tlast    <= 1'b0;
      pad_act    <= 1'b0;
      last_pend  <= 1'b0;
      first      <= 1'b0;
      final_blk  <= 1'b0;
      out_idx    <= '0;
    end else begin
      cmd <= '0;
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              blk        <= {blk[503:0], s_tdata};
              byte_count <= byte_count + 61'd1;
            end
            if (s_tuser && byte_count[5:0] == 6'(BLOCK_BYTES - 1)) begin
              cmd.start <= 1'b1;
              last_pend <= s_tlast;
              pad_act   <= 1'b0;
              state     <= COMP;
            end else if (s_tlast) begin
              state <= PAD_INIT;
            end
          end
        end
        PAD_INIT: begin
          fill      <= byte_count[5:0];
          final_blk <= (byte_count[5:0] < 6'(LEN_POS));
          len_sh    <= {byte_count, 3'b000};
          first     <= 1'b1;
          pad_act   <= 1'b1;
          last_pend <= 1'b0;
          state     <= PAD;
        end
        PAD: begin
          blk   <= {blk[503:0], pad_byte};
          first <= 1'b0;
          fill  <= fill + 6'd1;
          if (len_byte) len_sh <= {len_sh[55:0], 8'h00};
          if (fill == 6'(BLOCK_BYTES - 1)) begin
            cmd.start <= 1'b1;
            state     <= COMP;
          end
        end
        COMP: begin
          if (sts.done) begin
            if (pad_act) begin
              if (final_blk) begin
                m_tdata  <= hash[0];
                m_tvalid <= 1'b1;
                m_tlast  <= 1'b0;
                out_idx  <= '0;
                state    <= OUT;
              end else begin
                final_blk <= 1'b1;
                state     <= PAD;
              end
            end else if (last_pend) begin
              state <= PAD_INIT;
            end else begin
              state <= IDLE;
            end
          end
        end
        OUT: begin
          if (m_tready) begin
            if (out_idx == 3'd7) begin
              m_tvalid   <= 1'b0;
              m_tlast    <= 1'b0;
              cmd.init   <= 1'b1;
              byte_count <= '0;
              pad_act    <= 1'b0;
              state      <= IDLE;
            end else begin
              out_idx <= out_idx + 3'd1;
              m_tdata <= hash[out_idx + 3'd1];
              m_tlast <= (out_idx == 3'd6);
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Input and output sides are never open at the same time
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while digest pending");

  // word_last marks the eighth digest word only
  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> out_idx == 3'd7)
    else $error("word_last on wrong digest word");

  // Finishing the final block puts the first digest word out next cycle
  a_digest_out: assert property (@(posedge clk) disable iff (rst)
    (state == COMP && sts.done && pad_act && final_blk) |=> (m_tvalid && out_idx == 3'd0))
    else $error("digest not presented after final block");

  // A compression request is only raised together with the wait state, core free
  a_start_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (state == COMP && !sts.busy))
    else $error("compress request outside wait state");

endmodule
